// ===== hw/rtl/dmc_pkg.sv =====
// Shared types and constants for the direct-mapped cache.
// Holds the request/response beat structs and the controller/datapath links.
// No dependencies.
package dmc_pkg;

    localparam int ADDR_W  = 8;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [DATA_W-1:0]  read_data;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] miss_count;
    } rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic lookup;
        logic fill_step;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic in_write;
        logic lookup_hit;
        logic fill_last;
    } sts_t;

endpackage

// ===== hw/rtl/dmc_datapath.sv =====
// Datapath of the direct-mapped cache: main memory, tag and word stores,
// valid bits, hit/miss counters and the output register.
// Depends on dmc_pkg; driven by dmc_ctrl through dmc_pkg::cmd_t.
module dmc_datapath #(
    parameter int LINES          = 4,
    parameter int WORDS_PER_LINE = 4,
    parameter int MEMORY_BYTES   = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dmc_pkg::req_t req,
    input  dmc_pkg::cmd_t cmd,
    output dmc_pkg::sts_t sts,
    output dmc_pkg::rsp_t rsp
);

    localparam int MA_W  = $clog2(MEMORY_BYTES);
    localparam int WB    = $clog2(WORDS_PER_LINE);
    localparam int LB    = $clog2(LINES);
    localparam int LI_W  = LB;
    localparam int WI_W  = $clog2(LINES * WORDS_PER_LINE);
    localparam int TAG_W = (WB + LB >= dmc_pkg::ADDR_W) ? 1 : dmc_pkg::ADDR_W - WB - LB;
    localparam int FC_W  = $clog2(WORDS_PER_LINE + 1);

    localparam logic [dmc_pkg::ADDR_W-1:0] WORD_MASK = dmc_pkg::ADDR_W'(WORDS_PER_LINE - 1);
    localparam logic [dmc_pkg::ADDR_W-1:0] LINE_MASK = dmc_pkg::ADDR_W'(LINES - 1);

    logic [dmc_pkg::DATA_W-1:0] main_mem [MEMORY_BYTES];
    logic [dmc_pkg::DATA_W-1:0] words_mem [LINES * WORDS_PER_LINE];
    logic [TAG_W-1:0]           tags_mem [LINES];

    logic [MA_W-1:0]            clr_addr_reg;
    logic [FC_W-1:0]            fill_cnt_reg;
    logic [LINES-1:0]           valid_reg;
    logic [dmc_pkg::COUNT_W-1:0] hits_reg;
    logic [dmc_pkg::COUNT_W-1:0] misses_reg;

    logic                       req_mode_reg;
    logic [dmc_pkg::ADDR_W-1:0] req_addr_reg;
    logic [dmc_pkg::DATA_W-1:0] mem_rd_reg;
    logic [dmc_pkg::DATA_W-1:0] word_rd_reg;
    logic [TAG_W-1:0]           tag_rd_reg;
    logic                       res_hit_reg;
    logic [dmc_pkg::DATA_W-1:0] res_data_reg;
    dmc_pkg::rsp_t              out_reg;

    logic [dmc_pkg::ADDR_W-1:0] in_line8;
    logic [dmc_pkg::ADDR_W-1:0] req_line8;
    logic [dmc_pkg::ADDR_W-1:0] req_tag8;
    logic [dmc_pkg::ADDR_W-1:0] req_word8;
    logic [dmc_pkg::ADDR_W-1:0] base8;
    logic [dmc_pkg::ADDR_W-1:0] fill_rd8;
    logic [dmc_pkg::ADDR_W-1:0] fill_wr8;
    logic [FC_W-1:0]            fill_prev;
    logic [LI_W-1:0]            req_line;
    logic [TAG_W-1:0]           req_tag;
    logic                       fill_rd_en;
    logic                       fill_wr_en;
    logic                       hit;

    assign in_line8  = (req.address >> WB) & LINE_MASK;
    assign req_line8 = (req_addr_reg >> WB) & LINE_MASK;
    assign req_tag8  = req_addr_reg >> (WB + LB);
    assign req_word8 = req_addr_reg & WORD_MASK;
    assign req_line  = req_line8[LI_W-1:0];
    assign req_tag   = req_tag8[TAG_W-1:0];

    assign base8     = req_addr_reg & ~WORD_MASK;
    assign fill_prev = fill_cnt_reg - FC_W'(1);
    assign fill_rd8  = base8 | dmc_pkg::ADDR_W'(fill_cnt_reg);
    assign fill_wr8  = base8 | dmc_pkg::ADDR_W'(fill_prev);

    // One fill step per cycle: read word i, write word i-1 from the last read
    assign fill_rd_en = cmd.fill_step && (fill_cnt_reg != FC_W'(WORDS_PER_LINE));
    assign fill_wr_en = cmd.fill_step && (fill_cnt_reg != '0);

    assign hit = valid_reg[req_line] && (tag_rd_reg == req_tag);

    assign sts.clr_last   = (clr_addr_reg == MA_W'(MEMORY_BYTES - 1));
    assign sts.in_write   = (req.mode == dmc_pkg::MODE_WRITE);
    assign sts.lookup_hit = hit;
    assign sts.fill_last  = (fill_cnt_reg == FC_W'(WORDS_PER_LINE));

    assign rsp = out_reg;

    // Main memory: clear sweep and byte writes share the single port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            main_mem[clr_addr_reg] <= '0;
        end
        else if (cmd.accept && req.mode == dmc_pkg::MODE_WRITE)
        begin
            main_mem[MA_W'(req.address)] <= req.write_data;
        end
        if (fill_rd_en)
        begin
            mem_rd_reg <= main_mem[MA_W'(fill_rd8)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_wr_en)
        begin
            words_mem[WI_W'(fill_wr8)] <= mem_rd_reg;
        end
        if (cmd.accept)
        begin
            word_rd_reg <= words_mem[WI_W'(req.address)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup && !hit)
        begin
            tags_mem[req_line] <= req_tag;
        end
        if (cmd.accept)
        begin
            tag_rd_reg <= tags_mem[in_line8[LI_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            fill_cnt_reg <= '0;
            valid_reg    <= '0;
            hits_reg     <= '0;
            misses_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + MA_W'(1);
            end
            if (cmd.lookup)
            begin
                fill_cnt_reg <= '0;
                if (hit)
                begin
                    if (hits_reg != dmc_pkg::COUNT_MAX)
                    begin
                        hits_reg <= hits_reg + dmc_pkg::COUNT_W'(1);
                    end
                end
                else
                begin
                    valid_reg[req_line] <= 1'b1;
                    if (misses_reg != dmc_pkg::COUNT_MAX)
                    begin
                        misses_reg <= misses_reg + dmc_pkg::COUNT_W'(1);
                    end
                end
            end
            else if (cmd.fill_step)
            begin
                fill_cnt_reg <= fill_cnt_reg + FC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_mode_reg <= req.mode;
            req_addr_reg <= req.address;
            res_hit_reg  <= 1'b0;
            res_data_reg <= '0;
        end
        if (cmd.lookup)
        begin
            res_hit_reg <= hit;
            if (hit)
            begin
                res_data_reg <= word_rd_reg;
            end
        end
        // Catch the addressed word as it streams into the line
        if (fill_wr_en && (dmc_pkg::ADDR_W'(fill_prev) == req_word8))
        begin
            res_data_reg <= mem_rd_reg;
        end
        if (cmd.load_out)
        begin
            out_reg.hit        <= res_hit_reg && (req_mode_reg == dmc_pkg::MODE_READ);
            out_reg.read_data  <= res_data_reg;
            out_reg.hit_count  <= hits_reg;
            out_reg.miss_count <= misses_reg;
        end
    end

endmodule

// ===== hw/rtl/dmc_ctrl.sv =====
// Controller of the direct-mapped cache: sequences clear, lookup, fill and
// response, and owns both handshakes. Depends on dmc_pkg.
module dmc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  dmc_pkg::sts_t sts,
    output dmc_pkg::cmd_t cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOKUP = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd.clr_step  = 1'b0;
        cmd.accept    = 1'b0;
        cmd.lookup    = 1'b0;
        cmd.fill_step = 1'b0;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.in_write ? S_RESP : S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = sts.lookup_hit ? S_RESP : S_FILL;
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || rsp_ready))
        else $error("output beat overwritten before it was taken");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second request taken while one is in flight");

    a_fill_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && sts.fill_last) |=> (state_reg == S_RESP))
        else $error("fill did not hand over to response");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd.load_out))
        else $error("response valid without a load");
`endif

endmodule

// ===== hw/rtl/direct_mapped_cache_top.sv =====
// Direct-mapped cache top level: dmc_ctrl plus dmc_datapath.
// One request at a time: a new request is taken only after the previous one
// has been loaded into the output register. A read miss fills its line from
// main memory one word per cycle.
// Reset: asynchronous, active low; afterward the main memory is zeroed by a
// sweep over all MEMORY_BYTES addresses, during which no request is taken.
module direct_mapped_cache_top #(
    parameter int LINES          = 4,
    parameter int WORDS_PER_LINE = 4,
    parameter int MEMORY_BYTES   = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  dmc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output dmc_pkg::rsp_t rsp
);

    dmc_pkg::cmd_t cmd;
    dmc_pkg::sts_t sts;

    dmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dmc_datapath #(
        .LINES          (LINES),
        .WORDS_PER_LINE (WORDS_PER_LINE),
        .MEMORY_BYTES   (MEMORY_BYTES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

// ===== tb/tb_direct_mapped_cache_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for direct_mapped_cache_top: request beats from a queue,
// responses checked against a shadow cache and main memory kept in the bench.
// Depends on dmc_pkg and the direct_mapped_cache_top RTL.
module tb_direct_mapped_cache_top;

    localparam int LINES          = 4;
    localparam int WORDS_PER_LINE = 4;
    localparam int MEMORY_BYTES   = 256;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int CALM_START     = 400;
    localparam int CALM_LEN       = 300;
    localparam int CYCLE_LIMIT    = 5000000;
    localparam int DRAIN_CYCLES   = 16;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    dmc_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    dmc_pkg::rsp_t rsp;

    // Shadow of the cache and main memory
    logic [dmc_pkg::DATA_W-1:0]  mem_img [MEMORY_BYTES];
    logic [3:0]                  tag_img [LINES];
    logic                        valid_img [LINES];
    logic [dmc_pkg::DATA_W-1:0]  word_img [LINES*WORDS_PER_LINE];
    logic [dmc_pkg::COUNT_W-1:0] hits_img;
    logic [dmc_pkg::COUNT_W-1:0] misses_img;

    dmc_pkg::req_t req_backlog[$];
    dmc_pkg::rsp_t awaited_rsps[$];
    int   total_reqs  = 0;
    int   issued      = 0;
    int   accepted    = 0;
    int   received    = 0;
    int   errors      = 0;
    int   cycle_count = 0;
    int   calm_from   = 0;
    int   calm_to     = 0;

    direct_mapped_cache_top #(
        .LINES          (LINES),
        .WORDS_PER_LINE (WORDS_PER_LINE),
        .MEMORY_BYTES   (MEMORY_BYTES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one request to the shadow state and return the response it should give
    function automatic dmc_pkg::rsp_t cache_access(dmc_pkg::req_t item);
        dmc_pkg::rsp_t     r;
        logic [5:0]        block;
        logic [1:0]        line;
        logic [3:0]        tag;
        logic [1:0]        w;
        int                i;
        r = '0;
        if (item.mode == dmc_pkg::MODE_WRITE)
        begin
            mem_img[item.address] = item.write_data;
        end
        else
        begin
            block = item.address[7:2];
            line  = block[1:0];
            tag   = block[5:2];
            if (valid_img[line] && tag_img[line] == tag)
            begin
                r.hit = 1'b1;
                if (hits_img != dmc_pkg::COUNT_MAX)
                    hits_img = hits_img + 1'b1;
            end
            else
            begin
                for (i = 0; i < WORDS_PER_LINE; i++)
                begin
                    w = i[1:0];
                    word_img[{line, w}] = mem_img[{block, w}];
                end
                tag_img[line]   = tag;
                valid_img[line] = 1'b1;
                if (misses_img != dmc_pkg::COUNT_MAX)
                    misses_img = misses_img + 1'b1;
            end
            r.read_data = word_img[{line, item.address[1:0]}];
        end
        r.hit_count  = hits_img;
        r.miss_count = misses_img;
        return r;
    endfunction

    function automatic dmc_pkg::req_t read_beat(logic [dmc_pkg::ADDR_W-1:0] addr);
        dmc_pkg::req_t b;
        b.mode       = dmc_pkg::MODE_READ;
        b.address    = addr;
        b.write_data = dmc_pkg::DATA_W'($urandom);
        return b;
    endfunction

    function automatic dmc_pkg::req_t write_beat(logic [dmc_pkg::ADDR_W-1:0] addr,
                                                 logic [dmc_pkg::DATA_W-1:0] data);
        dmc_pkg::req_t b;
        b.mode       = dmc_pkg::MODE_WRITE;
        b.address    = addr;
        b.write_data = data;
        return b;
    endfunction

    task automatic report(string msg);
        errors++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Driver: hold the beat until accepted, then load the next one or idle
    always @(posedge clk)
    begin
        logic calm;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                awaited_rsps.push_back(cache_access(req));
                accepted++;
            end
            if (!req_valid || req_ready)
            begin
                calm = issued >= calm_from && issued < calm_to;
                if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 6))
                begin
                    req_valid <= 1'b1;
                    req       <= req_backlog.pop_front();
                    issued++;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each response beat with the oldest outstanding one
    always @(posedge clk)
    begin
        dmc_pkg::rsp_t want;
        logic          calm;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsps.size() == 0)
                begin
                    report($sformatf("response %0d arrived with nothing outstanding", received));
                end
                else
                begin
                    want = awaited_rsps.pop_front();
                    if (rsp.hit !== want.hit)
                        report($sformatf("response %0d hit: expected %0d got %0d",
                                         received, want.hit, rsp.hit));
                    if (rsp.read_data !== want.read_data)
                        report($sformatf("response %0d read_data: expected %0h got %0h",
                                         received, want.read_data, rsp.read_data));
                    if (rsp.hit_count !== want.hit_count)
                        report($sformatf("response %0d hit_count: expected %0d got %0d",
                                         received, want.hit_count, rsp.hit_count));
                    if (rsp.miss_count !== want.miss_count)
                        report($sformatf("response %0d miss_count: expected %0d got %0d",
                                         received, want.miss_count, rsp.miss_count));
                end
                received++;
            end
            calm = received >= calm_from && received < calm_to;
            rsp_ready <= calm || $urandom_range(99) >= 6;
        end
    end

    initial
    begin
        logic [3:0]                 tag;
        logic [dmc_pkg::ADDR_W-1:0] addr;
        int                         i;
        int                         k;

        for (i = 0; i < MEMORY_BYTES; i++)
            mem_img[i] = '0;
        for (i = 0; i < LINES; i++)
        begin
            tag_img[i]   = '0;
            valid_img[i] = 1'b0;
        end
        for (i = 0; i < LINES*WORDS_PER_LINE; i++)
            word_img[i] = '0;
        hits_img   = '0;
        misses_img = '0;

        // Directed: cold miss on cleared memory, hit, stale line after a memory
        // write, eviction by another tag, address and data extremes
        req_backlog.push_back(read_beat(8'h00));
        req_backlog.push_back(read_beat(8'h03));
        req_backlog.push_back(write_beat(8'hFF, 8'hFF));
        req_backlog.push_back(write_beat(8'h00, 8'hA5));
        req_backlog.push_back(write_beat(8'h01, 8'h5A));
        req_backlog.push_back(read_beat(8'h00));
        req_backlog.push_back(read_beat(8'hF0));
        req_backlog.push_back(read_beat(8'h00));
        req_backlog.push_back(read_beat(8'h01));
        req_backlog.push_back(read_beat(8'hFF));
        req_backlog.push_back(read_beat(8'hFC));
        req_backlog.push_back(write_beat(8'h80, 8'h00));
        req_backlog.push_back(write_beat(8'h7F, 8'hAA));
        req_backlog.push_back(write_beat(8'h55, 8'h55));
        req_backlog.push_back(read_beat(8'h7F));
        req_backlog.push_back(read_beat(8'hFF));
        req_backlog.push_back(read_beat(8'h54));
        req_backlog.push_back(read_beat(8'h55));
        req_backlog.push_back(read_beat(8'h80));

        // Run a stretch of the random beats with no idling on either side
        calm_from = req_backlog.size() + CALM_START;
        calm_to   = calm_from + CALM_LEN;

        // Random: tags mostly from a small pool so lines hit, evict and go stale
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            tag  = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(2));
            addr = {tag, 4'($urandom)};
            if ($urandom_range(99) < 5)
                req_backlog.push_back(write_beat(dmc_pkg::ADDR_W'($urandom),
                                                 dmc_pkg::DATA_W'($urandom)));
            else if ($urandom_range(99) < 25)
                req_backlog.push_back(write_beat(addr, dmc_pkg::DATA_W'($urandom)));
            else
                req_backlog.push_back(read_beat(addr));
        end

        for (k = 0; k < 12; k++)
        begin
            if (k[0])
                req_backlog.push_back(write_beat(dmc_pkg::ADDR_W'($urandom),
                                                 dmc_pkg::DATA_W'($urandom)));
            else
                req_backlog.push_back(read_beat(dmc_pkg::ADDR_W'($urandom)));
        end
        total_reqs = req_backlog.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted < total_reqs || awaited_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dmc_pkg.sv
hw/rtl/dmc_datapath.sv
hw/rtl/dmc_ctrl.sv
hw/rtl/direct_mapped_cache_top.sv
tb/tb_direct_mapped_cache_top.sv
